### rtl/ffsa_pkg.sv
package ffsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int SIZE_W           = 16;
    localparam int HDR_W            = 8;
    localparam int ENT_W            = SIZE_W + 1;
    localparam int PADDR_W          = 3;

    localparam logic [SIZE_W-1:0] AREA_RESET   = 16'd8192;
    localparam logic [HDR_W-1:0]  HEADER_RESET = 8'd28;

    localparam logic REG_AREA   = 1'b0;
    localparam logic REG_HEADER = 1'b1;

    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_NO_FIT    = 3'd1,
        ST_ALREADY   = 3'd2,
        ST_UNKNOWN   = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

endpackage

### rtl/ffsa_ram.sv
module ffsa_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/first_fit_segment_allocator_top.sv
// First-fit segment allocator with coalescing.
// Input stream: tuser = kind (0 allocate, 1 free); tdata carries req_size and handle.
// Output stream: one transaction per input transaction with status and granted offset.
// The segment table (free bit and size per entry) lives in one synchronous RAM with
// a registered read; a counter holds the number of live entries.
// An item scans the table one entry per cycle from entry 0 until it hits, then
// shifts the entries above the hit point one per cycle (up on allocate, down on a
// merging free). One item is in flight at a time and the input is ready again in
// the cycle the result appears.
// The result waits in an output register; the input side accepts the next item
// while it waits, and the block stalls at the end of that item until the receiver
// takes the earlier result.
// Reset sets area_size 8192, header_bytes 28 and rewrites entry 0 as a single free
// segment. A write to area_size does the same; writes to header_bytes leave the
// table alone. Users must write configuration only while idle; it is not enforced.
module first_fit_segment_allocator_top #(
    parameter int MAX_SEGMENTS = ffsa_pkg::MAX_SEGMENTS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [31:0]                  s_axis_tdata,  // req_size[15:0], handle[31:16]
    input  logic                         s_axis_tuser,  // kind
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [23:0]                  m_axis_tdata,  // status[2:0], granted_offset[18:3]
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ffsa_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int SW = ffsa_pkg::SIZE_W;
    localparam int EW = ffsa_pkg::ENT_W;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_FNEXT, S_MOVE, S_AW1, S_AW2, S_RESP
    } t_state;

    t_state            r_state, n_state, r_after, n_after;
    logic [SW-1:0]     r_area;
    logic [7:0]        r_hdr;
    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_kind, n_kind;
    logic [SW-1:0]     r_handle, n_handle;
    logic [SW:0]       r_need, n_need;
    logic [SW:0]       r_off, n_off;
    logic [CW-1:0]     r_ri, n_ri;
    logic [CW-1:0]     r_pi, n_pi;
    logic              r_pv, n_pv;
    logic [CW-1:0]     r_idx, n_idx;
    logic [EW-1:0]     r_cur, n_cur;
    logic [EW-1:0]     r_prev, n_prev;
    logic [CW-1:0]     r_src, n_src;
    logic [CW-1:0]     r_end, n_end;
    logic              r_go, n_go;
    logic              r_up, n_up;
    logic [1:0]        r_dist, n_dist;
    logic              r_pend, n_pend;
    logic [CW-1:0]     r_dst, n_dst;
    logic              r_out_valid;
    logic [23:0]       r_out_data;
    logic [2:0]        res_status;
    logic [SW-1:0]     res_offset;
    logic              res_load;

    logic              ram_we;
    logic [IW-1:0]     ram_wa, ram_ra;
    logic [EW-1:0]     ram_wd, ram_rd;

    logic              cfg_wr;
    logic              hit;
    logic              nf, pf;
    logic [SW+1:0]     total;
    logic [CW-1:0]     src0;

    ffsa_ram #(.WIDTH(EW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_raddr (ram_ra),
        .o_rdata (ram_rd)
    );

    assign cfg_wr        = psel && penable && pwrite;
    assign pready        = 1'b1;
    assign prdata        = paddr[2] ? {24'd0, r_hdr} : {16'd0, r_area};
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign hit = (r_kind == ffsa_pkg::KIND_FREE) ? (r_off == {1'b0, r_handle})
                 : (ram_rd[SW] && ({1'b0, ram_rd[SW-1:0]} > r_need));
    assign nf    = ((r_idx + 1'b1) < r_cnt) && ram_rd[SW];
    assign pf    = (r_idx != '0) && r_prev[SW];
    assign total = {2'b0, r_cur[SW-1:0]} + (nf ? {2'b0, ram_rd[SW-1:0]} : '0)
                   + (pf ? {2'b0, r_prev[SW-1:0]} : '0);
    assign src0  = r_idx + 1'b1 + CW'(nf);

    always_comb begin
        n_state = r_state; n_after = r_after; n_cnt = r_cnt;
        n_kind = r_kind; n_handle = r_handle; n_need = r_need; n_off = r_off;
        n_ri = r_ri; n_pi = r_pi; n_pv = r_pv; n_idx = r_idx; n_cur = r_cur;
        n_prev = r_prev; n_src = r_src; n_end = r_end; n_go = r_go; n_up = r_up;
        n_dist = r_dist; n_pend = r_pend; n_dst = r_dst;
        ram_we = 1'b0; ram_wa = '0; ram_wd = '0; ram_ra = '0;
        res_status = ffsa_pkg::ST_OK; res_offset = '0; res_load = 1'b0;
        unique case (r_state)
            S_INIT: begin
                ram_we  = 1'b1;
                ram_wd  = {1'b1, r_area};
                n_cnt   = CW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (cfg_wr && paddr[2] == ffsa_pkg::REG_AREA) begin
                    n_state = S_INIT;
                end else if (s_axis_tvalid) begin
                    n_kind   = s_axis_tuser;
                    n_handle = s_axis_tdata[31:16];
                    n_need   = {1'b0, s_axis_tdata[15:0]} + {9'd0, r_hdr};
                    n_off    = '0;
                    n_ri     = '0;
                    n_pv     = 1'b0;
                    n_state  = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_ri < r_cnt) begin
                    ram_ra = r_ri[IW-1:0];
                    n_ri   = r_ri + 1'b1;
                    n_pi   = r_ri;
                    n_pv   = 1'b1;
                end else begin
                    n_pv = 1'b0;
                end
                if (r_pv && hit) begin
                    n_idx = r_pi;
                    n_cur = ram_rd;
                    if (r_kind == ffsa_pkg::KIND_ALLOC) begin
                        if (r_cnt >= MAX_CNT) begin
                            res_status = ffsa_pkg::ST_FULL;
                            n_state    = S_RESP;
                        end else begin
                            n_src   = r_cnt - 1'b1;
                            n_end   = r_pi + 1'b1;
                            n_go    = r_cnt > (r_pi + 1'b1);
                            n_up    = 1'b0;
                            n_pend  = 1'b0;
                            n_after = S_AW1;
                            n_state = S_MOVE;
                        end
                    end else if (ram_rd[SW]) begin
                        res_status = ffsa_pkg::ST_ALREADY;
                        n_state    = S_RESP;
                    end else begin
                        n_state = S_FNEXT;
                    end
                end else if (r_pv) begin
                    n_off  = r_off + {1'b0, ram_rd[SW-1:0]};
                    n_prev = ram_rd;
                end else if (r_ri >= r_cnt) begin
                    res_status = (r_kind == ffsa_pkg::KIND_FREE) ? ffsa_pkg::ST_UNKNOWN
                                                                 : ffsa_pkg::ST_NO_FIT;
                    n_state    = S_RESP;
                end
            end
            S_FNEXT: begin
                ram_we  = 1'b1;
                ram_wa  = IW'(r_idx - CW'(pf));
                ram_wd  = {1'b1, total[SW-1:0]};
                n_dist  = {1'b0, nf} + {1'b0, pf};
                n_src   = src0;
                n_end   = r_cnt - 1'b1;
                n_go    = (nf || pf) && (src0 < r_cnt);
                n_up    = 1'b1;
                n_pend  = 1'b0;
                n_cnt   = r_cnt - CW'(nf) - CW'(pf);
                n_after = S_RESP;
                n_state = S_MOVE;
            end
            S_MOVE: begin
                if (r_go) begin
                    ram_ra = r_src[IW-1:0];
                    n_pend = 1'b1;
                    n_dst  = r_up ? (r_src - CW'(r_dist)) : (r_src + 1'b1);
                    if (r_src == r_end) begin
                        n_go = 1'b0;
                    end else begin
                        n_src = r_up ? (r_src + 1'b1) : (r_src - 1'b1);
                    end
                end else begin
                    n_pend = 1'b0;
                end
                if (r_pend) begin
                    ram_we = 1'b1;
                    ram_wa = r_dst[IW-1:0];
                    ram_wd = ram_rd;
                end
                if (!r_go && !r_pend) begin
                    n_state = r_after;
                end
            end
            S_AW1: begin
                ram_we  = 1'b1;
                ram_wa  = IW'(r_idx + 1'b1);
                ram_wd  = {1'b1, r_cur[SW-1:0] - r_need[SW-1:0]};
                n_state = S_AW2;
            end
            S_AW2: begin
                ram_we  = 1'b1;
                ram_wa  = r_idx[IW-1:0];
                ram_wd  = {1'b0, r_need[SW-1:0]};
                n_cnt   = r_cnt + 1'b1;
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!r_out_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (r_state == S_SCAN && n_state == S_RESP) begin
            res_load = 1'b1;
        end else if (r_state == S_AW2 || (r_state == S_MOVE && n_state == S_RESP)) begin
            res_load   = 1'b1;
            res_offset = (r_after == S_AW1) ? r_off[SW-1:0] : '0;
        end
    end

    logic [2:0]    r_res_status;
    logic [SW-1:0] r_res_offset;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_after     <= S_RESP;
            r_area      <= ffsa_pkg::AREA_RESET;
            r_hdr       <= ffsa_pkg::HEADER_RESET;
            r_cnt       <= CW'(1);
            r_pv        <= 1'b0;
            r_go        <= 1'b0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_after <= n_after;
            r_cnt   <= n_cnt;
            r_pv    <= n_pv;
            r_go    <= n_go;
            r_pend  <= n_pend;
            if (cfg_wr && paddr[2] == ffsa_pkg::REG_AREA) begin
                r_area <= pwdata[SW-1:0];
            end
            if (cfg_wr && paddr[2] == ffsa_pkg::REG_HEADER) begin
                r_hdr <= pwdata[7:0];
            end
            if (r_state == S_RESP && (!r_out_valid || m_axis_tready)) begin
                r_out_valid <= 1'b1;
                r_out_data  <= {5'd0, r_res_offset, r_res_status};
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        r_kind   <= n_kind;
        r_handle <= n_handle;
        r_need   <= n_need;
        r_off    <= n_off;
        r_ri     <= n_ri;
        r_pi     <= n_pi;
        r_idx    <= n_idx;
        r_cur    <= n_cur;
        r_prev   <= n_prev;
        r_src    <= n_src;
        r_end    <= n_end;
        r_up     <= n_up;
        r_dist   <= n_dist;
        r_dst    <= n_dst;
        if (res_load) begin
            r_res_status <= res_status;
            r_res_offset <= res_offset;
        end
    end

endmodule

### rtl/ffsa_chk.sv
module ffsa_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[2:0] <= ffsa_pkg::ST_FULL)
        else $error("status out of range");

    a_offset_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[2:0] != ffsa_pkg::ST_OK |-> m_axis_tdata[18:3] == 16'd0)
        else $error("offset on failed transaction");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready while busy");

endmodule

bind first_fit_segment_allocator_top ffsa_chk u_ffsa_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
